>>> rtl/tta_pkg.sv
`default_nettype none

package tta_pkg;

    // Register file layout.
    localparam int SIZE_REGS    = 4;
    localparam int SIZE_W       = 9;
    localparam int AXIS_FIELD_W = 2;
    localparam int AXIS_W       = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;

    // Payload widths.
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd1;
    localparam logic [AXIS_W-1:0] AXIS_RESET = 8'd228;

    typedef logic [AXIS_FIELD_W-1:0] axis_sel_t;

    typedef struct packed {
        logic advance;
        logic restart;
    } odo_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/tensor_transpose_address_generator_unit.sv
`default_nettype none

// Transposing address generator. Takes one word per cycle in source
// row-major order and presents for each accepted source word a result
// word: the element's row-major index in the permuted tensor, with the
// value passed through. The source word is registered when it is accepted,
// the products are registered in the next stage, and the summed index is
// registered in the stage after that; res_stall can hold each stage.
// Source coordinates come from a per-dimension odometer, so no divider is
// needed; the index is the sum of coordinate times stride, with the
// multipliers and the adder tree in separate stages. The output strides are
// computed by a small multiplier chain from the size and axis order
// registers; while it settles, src_stall is held high by a settle counter
// that is reloaded at reset and at every configuration write.
// Outside the settle window the block sustains one word per cycle as long as
// res_stall stays low.
module tensor_transpose_address_generator_unit
    import tta_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  src_valid,
    output logic                       src_stall,
    input  wire logic [DATA_W-1:0]     element_value,
    input  wire logic                  first,

    output logic                       res_valid,
    input  wire logic                  res_stall,
    output logic      [INDEX_W-1:0]    dest_index,
    output logic      [DATA_W-1:0]     element_out,
    output logic                       last,
    output logic                       order_error
);

    localparam int XW       = (SIZE_W > DIM_BITS) ? SIZE_W : DIM_BITS;
    localparam int SETTLE   = MAX_RANK + 1;
    localparam int SETTLE_W = $clog2(SETTLE + 1);
    localparam logic [XW-1:0] POS_MAX = XW'((64'd1 << DIM_BITS) - 64'd1);

    logic [SIZE_W-1:0]   size_reg [SIZE_REGS];
    logic [AXIS_W-1:0]   axis_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic                cfg_write;

    logic [DIM_BITS-1:0] extm1      [MAX_RANK];
    logic [INDEX_W-1:0]  src_stride [MAX_RANK];
    logic                bad;

    odo_ctrl_t           odo_ctrl;
    logic [DIM_BITS-1:0] pos_use [MAX_RANK];
    logic                is_last;

    logic                src_accept;
    logic                a_free;
    logic                b_free;
    logic                c_take;

    logic                a_valid_reg;
    logic [DIM_BITS-1:0] a_pos_reg [MAX_RANK];
    logic [DATA_W-1:0]   a_value_reg;
    logic                a_last_reg;

    logic                b_valid_reg;
    logic [INDEX_W-1:0]  b_prod_reg [MAX_RANK];
    logic [DATA_W-1:0]   b_value_reg;
    logic                b_last_reg;

    logic                c_valid_reg;
    logic [INDEX_W-1:0]  c_index_reg;
    logic [DATA_W-1:0]   c_value_reg;
    logic                c_last_reg;
    logic                c_error_reg;
    logic [INDEX_W-1:0]  dest_sum;

    // ---------------- configuration ----------------

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < SIZE_REGS; d++)
            begin
                size_reg[d] <= SIZE_RESET;
            end
            axis_reg <= AXIS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIZE_DIM0:  size_reg[0] <= cfg_data;
                REG_SIZE_DIM1:  size_reg[1] <= cfg_data;
                REG_SIZE_DIM2:  size_reg[2] <= cfg_data;
                REG_SIZE_DIM3:  size_reg[3] <= cfg_data;
                REG_AXIS_ORDER: axis_reg    <= cfg_data[AXIS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_W'(SETTLE);
        end
        else if (cfg_write)
        begin
            settle_reg <= SETTLE_W'(SETTLE);
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    // Final coordinate of each source axis: size zero acts as one, and
    // sizes above the counter range are clamped to it.
    for (genvar d = 0; d < MAX_RANK; d++)
    begin : g_ext
        if (d < SIZE_REGS)
        begin : g_reg
            logic [XW-1:0] em1;
            assign em1      = (size_reg[d] == '0) ? '0 : XW'(size_reg[d]) - 1'b1;
            assign extm1[d] = DIM_BITS'((em1 > POS_MAX) ? POS_MAX : em1);
        end
        else
        begin : g_unit
            assign extm1[d] = '0;
        end
    end

    tta_stride #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_stride (
        .clk        (clk),
        .rst_n      (rst_n),
        .axis_order (axis_reg),
        .extm1      (extm1),
        .src_stride (src_stride),
        .bad        (bad)
    );

    // ---------------- pipeline control ----------------

    assign c_take     = !c_valid_reg || !res_stall;
    assign b_free     = !b_valid_reg || c_take;
    assign a_free     = !a_valid_reg || b_free;
    assign src_stall  = !a_free || (settle_reg != '0);
    assign src_accept = src_valid && !src_stall;

    assign odo_ctrl.advance = src_accept;
    assign odo_ctrl.restart = first;

    tta_odometer #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_odometer (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (odo_ctrl),
        .extm1   (extm1),
        .pos_use (pos_use),
        .is_last (is_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= src_accept;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_take)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // ---------------- datapath ----------------

    always_comb
    begin
        dest_sum = '0;
        for (int d = 0; d < MAX_RANK; d++)
        begin
            dest_sum = dest_sum + b_prod_reg[d];
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            a_pos_reg   <= pos_use;
            a_value_reg <= element_value;
            a_last_reg  <= is_last;
        end
        if (a_valid_reg && b_free)
        begin
            for (int d = 0; d < MAX_RANK; d++)
            begin
                b_prod_reg[d] <= INDEX_W'(src_stride[d] * a_pos_reg[d]);
            end
            b_value_reg <= a_value_reg;
            b_last_reg  <= a_last_reg;
        end
        if (b_valid_reg && c_take)
        begin
            c_index_reg <= bad ? '0 : dest_sum;
            c_value_reg <= b_value_reg;
            c_last_reg  <= b_last_reg;
            c_error_reg <= bad;
        end
    end

    assign res_valid   = c_valid_reg;
    assign dest_index  = c_index_reg;
    assign element_out = c_value_reg;
    assign last        = c_last_reg;
    assign order_error = c_error_reg;

endmodule

`default_nettype wire

>>> rtl/tta_odometer.sv
`default_nettype none

module tta_odometer
    import tta_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire odo_ctrl_t           ctrl,
    input  wire logic [DIM_BITS-1:0] extm1 [MAX_RANK],
    output logic      [DIM_BITS-1:0] pos_use [MAX_RANK],
    output logic                     is_last
);

    logic [DIM_BITS-1:0] pos_reg  [MAX_RANK];
    logic [DIM_BITS-1:0] pos_next [MAX_RANK];
    logic [MAX_RANK-1:0] at_end;

    always_comb
    begin
        for (int d = 0; d < MAX_RANK; d++)
        begin
            pos_use[d] = ctrl.restart ? '0 : pos_reg[d];
            // A counter beyond a shrunken extent still counts as final.
            at_end[d]  = (pos_use[d] >= extm1[d]);
        end
        is_last = &at_end;
    end

    // Innermost dimension counts fastest; the carry ripples outward.
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--)
        begin
            if (carry)
            begin
                pos_next[d] = at_end[d] ? '0 : pos_use[d] + 1'b1;
            end
            else
            begin
                pos_next[d] = pos_use[d];
            end
            carry = carry & at_end[d];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_RANK; d++)
            begin
                pos_reg[d] <= '0;
            end
        end
        else if (ctrl.advance)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tta_stride.sv
`default_nettype none

module tta_stride
    import tta_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [AXIS_W-1:0]   axis_order,
    input  wire logic [DIM_BITS-1:0] extm1 [MAX_RANK],
    output logic      [INDEX_W-1:0]  src_stride [MAX_RANK],
    output logic                     bad
);

    axis_sel_t           perm    [MAX_RANK];
    logic [DIM_BITS:0]   ext_sel [MAX_RANK];
    logic [INDEX_W-1:0]  stride_reg   [MAX_RANK];
    logic [INDEX_W-1:0]  stride_next  [MAX_RANK];
    logic [INDEX_W-1:0]  sstride_reg  [MAX_RANK];
    logic [INDEX_W-1:0]  sstride_next [MAX_RANK];
    logic                bad_reg;
    logic                bad_next;

    // Output axes past the register's four fields read source axis zero.
    for (genvar i = 0; i < MAX_RANK; i++)
    begin : g_perm
        if (i < AXIS_W / AXIS_FIELD_W)
        begin : g_field
            assign perm[i] = axis_order[AXIS_FIELD_W*i +: AXIS_FIELD_W];
        end
        else
        begin : g_zero
            assign perm[i] = '0;
        end
    end

    always_comb
    begin
        bad_next = 1'b0;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if (int'(perm[i]) >= MAX_RANK)
            begin
                bad_next = 1'b1;
            end
            for (int j = 0; j < i; j++)
            begin
                if (perm[i] == perm[j])
                begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RANK; i++)
        begin
            ext_sel[i] = (DIM_BITS+1)'(1);
            for (int d = 0; d < MAX_RANK; d++)
            begin
                if (int'(perm[i]) == d)
                begin
                    ext_sel[i] = {1'b0, extm1[d]} + 1'b1;
                end
            end
        end
    end

    // Strides of the output tensor settle one axis per cycle, innermost first.
    always_comb
    begin
        stride_next[MAX_RANK-1] = INDEX_W'(1);
        for (int i = 0; i < MAX_RANK - 1; i++)
        begin
            stride_next[i] = INDEX_W'(stride_reg[i+1] * ext_sel[i+1]);
        end
    end

    // Each source axis picks up the stride of the output axis it feeds.
    always_comb
    begin
        for (int d = 0; d < MAX_RANK; d++)
        begin
            sstride_next[d] = '0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                if (int'(perm[i]) == d)
                begin
                    sstride_next[d] = sstride_next[d] | stride_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stride_reg  <= stride_next;
        sstride_reg <= sstride_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg <= 1'b0;
        end
        else
        begin
            bad_reg <= bad_next;
        end
    end

    assign src_stride = sstride_reg;
    assign bad        = bad_reg;

endmodule

`default_nettype wire

>>> dv/tta_scatter_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, source and result channels of the transposing
// address generator. It keeps its own copy of the registers and of the
// source odometer, works out the scatter word for every accepted source word
// and compares each accepted result word with the oldest one still pending.
module tta_scatter_checker
    import tta_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  src_valid,
    input  wire logic                  src_stall,
    input  wire logic [DATA_W-1:0]     element_value,
    input  wire logic                  first,

    input  wire logic                  res_valid,
    input  wire logic                  res_stall,
    input  wire logic [INDEX_W-1:0]    dest_index,
    input  wire logic [DATA_W-1:0]     element_out,
    input  wire logic                  last,
    input  wire logic                  order_error,

    output int                         fail_count,
    output int                         words_in_flight
);

    localparam int RANK       = 4;
    localparam int POS_W      = 8;
    localparam int MAX_EXTENT = 1 << POS_W;

    typedef struct packed {
        logic [INDEX_W-1:0] dest_index;
        logic [DATA_W-1:0]  element;
        logic               last;
        logic               order_error;
    } scatter_t;

    logic [SIZE_W-1:0] size_cfg [SIZE_REGS];
    logic [AXIS_W-1:0] axis_cfg;
    logic [POS_W-1:0]  coord [RANK];
    scatter_t          scatter_q [$];

    function automatic int unsigned extent(input int d);
        int unsigned e;
        if (d >= SIZE_REGS)
            return 1;
        e = size_cfg[d];
        if (e == 0)
            e = 1;
        if (e > MAX_EXTENT)
            e = MAX_EXTENT;
        return e;
    endfunction

    // Produces the scatter word for the current source coordinates and then
    // steps the odometer, innermost dimension fastest.
    function automatic scatter_t scatter_of(input logic [DATA_W-1:0] value,
                                            input logic restart);
        int unsigned ext [RANK];
        int          src_axis [RANK];
        int          out_axis [RANK];
        bit          taken [RANK];
        bit          bad;
        bit          carry;
        logic [63:0] stride [RANK];
        logic [63:0] acc;
        scatter_t    w;

        if (restart)
        begin
            for (int d = 0; d < RANK; d++)
                coord[d] = '0;
        end
        bad = 1'b0;
        for (int d = 0; d < RANK; d++)
        begin
            ext[d]      = extent(d);
            taken[d]    = 1'b0;
            out_axis[d] = 0;
        end
        for (int i = 0; i < RANK; i++)
        begin
            src_axis[i] = axis_cfg[AXIS_FIELD_W*i +: AXIS_FIELD_W];
            if (taken[src_axis[i]])
                bad = 1'b1;
            else
            begin
                taken[src_axis[i]]    = 1'b1;
                out_axis[src_axis[i]] = i;
            end
        end

        acc = '0;
        if (!bad)
        begin
            stride[RANK-1] = 64'd1;
            for (int i = RANK - 2; i >= 0; i--)
                stride[i] = stride[i+1] * ext[src_axis[i+1]];
            for (int d = 0; d < RANK; d++)
                acc += stride[out_axis[d]] * coord[d];
        end

        w.dest_index  = acc[INDEX_W-1:0];
        w.element     = value;
        w.order_error = bad;
        // A coordinate left beyond a shrunken extent counts as final.
        w.last = 1'b1;
        for (int d = 0; d < RANK; d++)
        begin
            if (coord[d] < ext[d] - 1)
                w.last = 1'b0;
        end

        carry = 1'b1;
        for (int d = RANK - 1; d >= 0; d--)
        begin
            if (carry)
            begin
                if (coord[d] >= ext[d] - 1)
                    coord[d] = '0;
                else
                begin
                    coord[d] = coord[d] + 1'b1;
                    carry    = 1'b0;
                end
            end
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        scatter_t want;
        if (!rst_n)
        begin
            for (int d = 0; d < SIZE_REGS; d++)
                size_cfg[d] = SIZE_RESET;
            axis_cfg = AXIS_RESET;
            for (int d = 0; d < RANK; d++)
                coord[d] = '0;
            scatter_q.delete();
            fail_count      = 0;
            words_in_flight = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIZE_DIM0:  size_cfg[0] = cfg_data[SIZE_W-1:0];
                    REG_SIZE_DIM1:  size_cfg[1] = cfg_data[SIZE_W-1:0];
                    REG_SIZE_DIM2:  size_cfg[2] = cfg_data[SIZE_W-1:0];
                    REG_SIZE_DIM3:  size_cfg[3] = cfg_data[SIZE_W-1:0];
                    REG_AXIS_ORDER: axis_cfg    = cfg_data[AXIS_W-1:0];
                    default:        ;
                endcase
            end

            if (src_valid && !src_stall)
                scatter_q.push_back(scatter_of(element_value, first));

            if (res_valid && !res_stall)
            begin
                if (scatter_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("checker: unexpected word idx %h val %h last %b err %b",
                                 dest_index, element_out, last, order_error);
                    fail_count++;
                end
                else
                begin
                    want = scatter_q.pop_front();
                    if (dest_index !== want.dest_index || element_out !== want.element ||
                        last !== want.last || order_error !== want.order_error)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("checker: mismatch want idx %h val %h last %b err %b",
                                     want.dest_index, want.element, want.last,
                                     want.order_error);
                            $display("checker:          got idx %h val %h last %b err %b",
                                     dest_index, element_out, last, order_error);
                        end
                        fail_count++;
                    end
                end
            end
            words_in_flight = scatter_q.size();
        end
    end

endmodule

>>> dv/tensor_transpose_address_generator_unit_test.sv
`timescale 1ns / 1ps

module tensor_transpose_address_generator_unit_test;
    import tta_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_WORDS = 1950;

    // Axis orders used by name in the directed part.
    localparam logic [AXIS_W-1:0] ORDER_REVERSE   = 8'h1B;
    localparam logic [AXIS_W-1:0] ORDER_ALL_ZERO  = 8'h00;
    localparam logic [AXIS_W-1:0] ORDER_ALL_THREE = 8'hFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  src_valid;
    logic                  src_stall;
    logic [DATA_W-1:0]     element_value;
    logic                  first;
    logic                  res_valid;
    logic                  res_stall;
    logic [INDEX_W-1:0]    dest_index;
    logic [DATA_W-1:0]     element_out;
    logic                  last;
    logic                  order_error;

    int                    fail_count;
    int                    words_in_flight;
    int                    words_sent;
    bit                    steady;
    bit                    hold_req;
    logic [SIZE_W-1:0]     cur_size [SIZE_REGS];

    tensor_transpose_address_generator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .element_value (element_value),
        .first         (first),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .dest_index    (dest_index),
        .element_out   (element_out),
        .last          (last),
        .order_error   (order_error)
    );

    tta_scatter_checker u_scatter_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .src_valid       (src_valid),
        .src_stall       (src_stall),
        .element_value   (element_value),
        .first           (first),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .dest_index      (dest_index),
        .element_out     (element_out),
        .last            (last),
        .order_error     (order_error),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return SIZE_W'($urandom_range(1, 4));
        if (r < 78)
            return SIZE_W'(1);
        if (r < 84)
            return SIZE_W'(0);
        if (r < 88)
            return SIZE_W'(256);
        if (r < 92)
            return SIZE_W'($urandom_range(257, 511));
        return SIZE_W'($urandom_range(5, 16));
    endfunction

    // Mostly a true permutation, sometimes any byte at all.
    function automatic logic [AXIS_W-1:0] pick_order();
        axis_sel_t         axes [4];
        axis_sel_t         t;
        int                j;
        logic [AXIS_W-1:0] order;
        if ($urandom_range(0, 9) < 3)
            return AXIS_W'($urandom_range(0, 255));
        for (int i = 0; i < 4; i++)
            axes[i] = axis_sel_t'(i);
        for (int i = 3; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = axes[i];
            axes[i] = axes[j];
            axes[j] = t;
        end
        for (int i = 0; i < 4; i++)
            order[AXIS_FIELD_W*i +: AXIS_FIELD_W] = axes[i];
        return order;
    endfunction

    function automatic longint unsigned elements_per_tensor();
        longint unsigned n;
        int unsigned     e;
        n = 1;
        for (int d = 0; d < SIZE_REGS; d++)
        begin
            e = cur_size[d];
            if (e == 0)
                e = 1;
            else if (e > 256)
                e = 256;
            n *= e;
        end
        return n;
    endfunction

    // Receiver: random stall runs, or one long hold-off when asked for.
    initial
    begin : receiver
        int run;
        run       = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                run      = HOLD_CYCLES;
            end
            if (run > 0)
            begin
                run--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
                if (!steady && $urandom_range(0, 99) < 25)
                    run = pick_gap_len();
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for a following word.
    task automatic send_word(input logic [DATA_W-1:0] value, input logic restart);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 45)
            gap = pick_gap_len();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid     <= 1'b1;
        element_value <= value;
        first         <= restart;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic settle();
        src_valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                             input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
                             input logic [AXIS_W-1:0] order);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx[0] = REG_SIZE_DIM0;
        idx[1] = REG_SIZE_DIM1;
        idx[2] = REG_SIZE_DIM2;
        idx[3] = REG_SIZE_DIM3;
        idx[4] = REG_AXIS_ORDER;
        val[0] = s0;
        val[1] = s1;
        val[2] = s2;
        val[3] = s3;
        val[4] = CFG_DATA_W'(order);
        cur_size[0] = s0;
        cur_size[1] = s1;
        cur_size[2] = s2;
        cur_size[3] = s3;
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // One setting, then whole tensors with random content; the first flag is
    // sometimes left off at a tensor start or set in the middle.
    task automatic random_phase(input bit with_hold);
        int              budget;
        int              k;
        longint unsigned len;
        longint unsigned n;
        settle();
        configure(pick_size(), pick_size(), pick_size(), pick_size(), pick_order());
        steady = with_hold || ($urandom_range(0, 4) == 0);
        if (with_hold)
        begin
            @(posedge clk);
            hold_req = 1'b1;
            @(negedge clk);
        end
        budget = $urandom_range(40, 150);
        k      = 0;
        while (k < budget)
        begin
            len = elements_per_tensor();
            for (n = 0; n < len && k < budget; n++)
            begin
                send_word($urandom(), (n == 0) ? ($urandom_range(0, 9) != 0)
                                               : ($urandom_range(0, 39) == 0));
                k++;
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SIZE_DIM0;
        cfg_data      = '0;
        src_valid     = 1'b0;
        element_value = '0;
        first         = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        words_sent    = 0;
        for (int d = 0; d < SIZE_REGS; d++)
            cur_size[d] = SIZE_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: every word is a whole tensor.
        send_word('0, 1'b0);
        send_word('1, 1'b1);
        settle();

        configure(9'd2, 9'd1, 9'd1, 9'd3, ORDER_REVERSE);
        for (int i = 0; i < 6; i++)
            send_word($urandom(), i == 0);
        settle();

        // Zero and oversized extents under an order that repeats an axis.
        configure(9'd0, 9'd511, 9'd2, 9'd1, ORDER_ALL_ZERO);
        for (int i = 0; i < 4; i++)
            send_word($urandom(), i == 0);
        settle();

        configure(9'd256, 9'd256, 9'd256, 9'd256, AXIS_RESET);
        for (int i = 0; i < 3; i++)
            send_word($urandom(), i == 0);
        settle();

        configure(9'd4, 9'd4, 9'd4, 9'd4, ORDER_ALL_THREE);
        for (int i = 0; i < 7; i++)
            send_word($urandom(), i == 0);
        settle();

        // Shrink the extents under the running odometer without a restart.
        configure(9'd1, 9'd1, 9'd2, 9'd2, ORDER_REVERSE);
        for (int i = 0; i < 3; i++)
            send_word($urandom(), 1'b0);

        phase = 0;
        while (words_sent < RANDOM_WORDS + 25)
        begin
            random_phase(phase == 0 || $urandom_range(0, 11) == 0);
            phase++;
        end

        settle();
        if (fail_count == 0 && words_in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/tta_pkg.sv
rtl/tta_odometer.sv
rtl/tta_stride.sv
rtl/tensor_transpose_address_generator_unit.sv
dv/tta_scatter_checker.sv
dv/tensor_transpose_address_generator_unit_test.sv
